@@ hdl/sha256_pkg.sv @@
// Package: SHA-256 constants, round constant table and a rotate-right function.
`default_nettype none
package sha256_pkg;
    localparam logic [31:0] IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

@@ hdl/sha256_stream_hasher.sv @@
// Top level: byte-stream SHA-256 hasher with one shared round unit.
// A byte that fills a block holds off input while the block is compressed (load, 64 rounds,
// chain add); other bytes are taken whenever the hasher is idle.
// End of message sweeps the rest of the block, or a fresh one, one byte per cycle before each
// padding compression (two when needed), then 8 output beats, one per cycle when taken.
// Synchronous active-low reset restores the initial hash values and a zero byte count.
`default_nettype none
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_number,
    output logic             o_last_word
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_h [0:7];
    logic [31:0] r_v [0:7];
    logic [31:0] r_w [0:15];  // message block bytes, then the schedule window
    logic [60:0] r_count;
    logic [5:0]  r_round;
    logic [6:0]  r_pidx;     // padding sweep index
    logic        r_final;    // current compression is the last of the message
    logic        r_second;   // a second padding block is needed
    logic [2:0]  r_onum;

    logic [5:0]  fill;
    logic [63:0] bits;
    logic [31:0] w_cur, g0, g1, s0, s1, ch, maj, t1, t2, w15, w2;
    assign fill = r_count[5:0];
    assign bits = {r_count, 3'b000};

    always_comb begin
        w15 = r_w[1];
        w2  = r_w[14];
        g0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        g1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        // window shifts each round: slot 0 is the current word for rounds 0-15, then w[r-16]
        w_cur = (r_round < 6'd16) ? r_w[0] : (r_w[0] + g0 + r_w[9] + g1);
        s1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + s1 + ch + round_k(r_round) + w_cur;
        s0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = s0 + maj;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_onum];
    assign o_word_number = r_onum;
    assign o_last_word   = (r_onum == 3'd7);

    // buffer-indexed padding byte for the second padding block or the tail
    function automatic logic [7:0] len_byte(input logic [63:0] b, input logic [2:0] i);
        return b[8*(7-i) +: 8];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_round  <= '0;
            r_pidx   <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_onum   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_byte_valid) begin
                            // big-endian byte lane of the block word
                            r_w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= i_data_byte;
                            r_count <= r_count + 61'd1;
                        end
                        r_final <= 1'b0;
                        if (i_byte_valid && fill == 6'd63) begin
                            r_second <= i_end_of_message;
                            r_state  <= S_LOAD;
                        end else if (i_end_of_message) begin
                            r_pidx  <= {1'b0, fill} + {6'd0, i_byte_valid};
                            r_state <= S_PAD;
                            r_second <= 1'b0;
                        end
                    end
                end
                S_PAD: begin
                    // one buffer byte per cycle; r_pidx from fill (or 0 for a fresh block) to 63
                    if (r_pidx[5:0] == fill && !r_second) begin
                        r_w[r_pidx[5:2]][{~r_pidx[1:0], 3'b000} +: 8] <= PAD_BYTE;
                    end else if (r_pidx[5:0] >= 6'd56 && !(fill >= 6'd56 && !r_second)) begin
                        r_w[r_pidx[5:2]][{~r_pidx[1:0], 3'b000} +: 8] <=
                            len_byte(bits, r_pidx[2:0]);
                    end else begin
                        r_w[r_pidx[5:2]][{~r_pidx[1:0], 3'b000} +: 8] <= 8'h00;
                    end
                    if (r_pidx[5:0] == 6'd63) begin
                        r_final <= !(fill >= 6'd56 && !r_second);
                        r_state <= S_LOAD;
                    end
                    r_pidx <= r_pidx + 7'd1;
                end
                S_LOAD: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_cur;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_final) begin
                        r_onum  <= '0;
                        r_state <= S_OUT;
                    end else if (r_second) begin
                        // message ended on a full block: pad a fresh block from byte 0
                        r_second <= 1'b0;
                        r_pidx   <= '0;
                        r_state  <= S_PAD;
                    end else if (fill >= 6'd56 && r_pidx[6]) begin
                        // first of two padding blocks done
                        r_second <= 1'b1;
                        r_pidx   <= '0;
                        r_state  <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_onum <= r_onum + 3'd1;
                        if (r_onum == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
                            r_count <= '0;
                            r_pidx  <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_word |=> o_ready) else $error("no return to idle");
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> r_state == S_ROUND && r_round == 6'd0)
        else $error("round counter not restarted");
`endif
endmodule
`default_nettype wire

@@ verif/sha256_checker.sv @@
// Checker: watches both channels, predicts SHA-256 digests and compares output beats.
`timescale 1ns / 100ps
`default_nettype none
module sha256_checker
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready_in,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_end_of_message,
    input  wire logic        i_valid_out,
    input  wire logic        i_ready,
    input  wire logic [31:0] i_digest_word,
    input  wire logic [2:0]  i_word_number,
    input  wire logic        i_last_word,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  num;
        logic        last;
    } t_digest_beat;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [7:0]  msg_block [0:63];
    logic [31:0] hash_state [0:7];
    logic [60:0] byte_total;
    t_digest_beat digest_q [$];
    int fails;

    assign o_fail_count = fails;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [0:63];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int r = 0; r < 64; r++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[r] + w[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic absorb_beat(input logic [7:0] data, input logic has_byte, input logic eom);
        int fill;
        logic [63:0] bit_len;
        if (has_byte) begin
            msg_block[byte_total[5:0]] = data;
            byte_total++;
            if (byte_total[5:0] == 0)
                compress();
        end
        if (eom) begin
            fill = byte_total[5:0];
            bit_len = {byte_total, 3'b000};
            msg_block[fill] = PAD_BYTE;
            for (int i = fill + 1; i < 64; i++)
                msg_block[i] = 8'h00;
            if (fill >= 56) begin
                compress();
                for (int i = 0; i < 64; i++)
                    msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                msg_block[56+i] = bit_len[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{hash_state[i], 3'(i), i == 7});
            for (int i = 0; i < 8; i++)
                hash_state[i] = IV[i];
            byte_total = '0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fails++;
    endtask

    initial begin
        fails = 0;
        o_pending = 0;
        byte_total = '0;
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV[i];
    end

    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n) begin
            if (i_valid && i_ready_in)
                absorb_beat(i_data_byte, i_byte_valid, i_end_of_message);
            if (i_valid_out && i_ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat word %h", i_digest_word));
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (i_digest_word !== exp_beat.word)
                        report_mismatch($sformatf("word %0d got %h want %h",
                            exp_beat.num, i_digest_word, exp_beat.word));
                    if (i_word_number !== exp_beat.num)
                        report_mismatch($sformatf("word_number got %0d want %0d",
                            i_word_number, exp_beat.num));
                    if (i_last_word !== exp_beat.last)
                        report_mismatch($sformatf("last_word got %b want %b",
                            i_last_word, exp_beat.last));
                end
            end
        end
        o_pending = digest_q.size();
    end
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Testbench top: drives byte stream and output backpressure, gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import sha256_pkg::*;

    logic        clk, rst_n;
    logic        in_valid, in_ready;
    logic [7:0]  data_byte;
    logic        byte_valid, eom;
    logic        out_valid, out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
    int          fail_count, pending;
    int          send_idle_pct, recv_idle_pct;
    logic        hold_off;

    sha256_stream_hasher i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(data_byte), .i_byte_valid(byte_valid), .i_end_of_message(eom),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_digest_word(digest_word), .o_word_number(word_number), .o_last_word(last_word)
    );

    sha256_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_data_byte(data_byte), .i_byte_valid(byte_valid), .i_end_of_message(eom),
        .i_valid_out(out_valid), .i_ready(out_ready),
        .i_digest_word(digest_word), .i_word_number(word_number), .i_last_word(last_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk) begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one beat; random idle cycles before offering it, valid stays up until it is taken
    task automatic send_beat(input logic [7:0] b, input logic bv, input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        byte_valid <= bv;
        eom        <= e;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_message(input int len, input logic end_with_byte);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom), 1'b1, end_with_byte && i == len - 1);
        if (!end_with_byte || len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        int len;
        rst_n = 1'b0;
        in_valid = 1'b0; data_byte = '0; byte_valid = 1'b0; eom = 1'b0;
        out_ready = 1'b0; hold_off = 1'b0;
        send_idle_pct = 17; recv_idle_pct = 45;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, byte extremes, ignored bytes, message ending on a full block
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1);
        send_message(64, 1'b1);

        // long receiver hold-off while sender keeps streaming
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_message(0, 1'b0);
                send_message(3, 1'b1);
                send_message(1, 1'b0);
                drain();
            end
        join

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 17 : 0;
            repeat (3) begin
                len = $urandom_range(0, 6);
                if ($urandom_range(4) == 0)
                    send_beat(8'($urandom), 1'b0, 1'b0);
                send_message(len, 1'($urandom_range(1)));
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS sha256_stream_hasher");
        else
            $display("FAIL sha256_stream_hasher");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL sha256_stream_hasher");
        $finish;
    end
endmodule
`default_nettype wire
